/* rtl/rtcf_pkg.sv */
// Shared types and constants for the radiotap capture filter ring.
// Used by every module of the block; depends on nothing else.
package rtcf_pkg;

   // Default geometry of the ring.
   localparam int NUM_SLOTS_DEF  = 64;
   localparam int SLOT_BYTES_DEF = 256;

   // Commands carried in the request tuser.
   typedef enum logic [1:0] {
      CMD_CAPTURE   = 2'd0,
      CMD_READ_HDR  = 2'd1,
      CMD_READ_BYTE = 2'd2,
      CMD_NONE      = 2'd3
   } cmd_type;

   // Register indexes of the configuration port.
   localparam logic [1:0] REG_FILT_DATA   = 2'd0;
   localparam logic [1:0] REG_FILT_BEACON = 2'd1;
   localparam logic [1:0] REG_SNAP        = 2'd2;

   // Frame-control type decoding and length limits.
   localparam logic [7:0]  TYPE_MASK   = 8'hFC;
   localparam logic [7:0]  TYPE_BEACON = 8'h80;
   localparam logic [7:0]  TYPE_DATA   = 8'h08;
   localparam logic [15:0] LEN_MAX     = 16'hFFFF;
   localparam logic [15:0] LEN_MIN     = 16'd8;
   localparam logic [8:0]  SNAP_RESET  = 9'd256;

   // Write request from the capture logic to the ring storage.
   typedef struct packed {
      logic        byte_we;
      logic        commit;
      logic [8:0]  keep;
      logic [15:0] frame_len;
   } cap_write_type;

   // One response beat, last field in the lowest bits.
   typedef struct packed {
      logic [31:0] filtered_total;
      logic [31:0] captured_total;
      logic        frame_dropped;
      logic        frame_kept;
      logic [7:0]  read_data;
      logic [19:0] entry_micros;
      logic [31:0] entry_seconds;
      logic [15:0] original_length;
      logic [8:0]  stored_length;
      logic        entry_valid;
   } rsp_type;

endpackage

/* rtl/rtcf_capture.sv */
// Capture front end: byte counter, header parse, drop decision, ring pointers
// and frame counters. Depends on rtcf_pkg.
module rtcf_capture
   import rtcf_pkg::*;
#(
   parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
   parameter int SLOT_BYTES = SLOT_BYTES_DEF,
   localparam int SW = $clog2(NUM_SLOTS),
   localparam int RW = $clog2(NUM_SLOTS + 1),
   localparam int IW = $clog2(SLOT_BYTES)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  cmd_type       cmd,
   input  logic [7:0]    data_byte,
   input  logic          frame_end,
   input  logic [5:0]    slot_offset,
   input  logic          filt_data,
   input  logic          filt_beacon,
   input  logic [8:0]    snap_length,
   output cap_write_type wr,
   output logic [SW-1:0] wr_slot,
   output logic [RW-1:0] wr_region,
   output logic [IW-1:0] wr_idx,
   output logic [SW-1:0] rd_slot,
   output logic          kept,
   output logic          dropped,
   output logic [31:0]   cap_total,
   output logic [31:0]   filt_total
);

   logic [15:0]   count_ff, count_in;
   logic [15:0]   hdr_ff, hdr_in;
   logic [7:0]    type_ff, type_in;
   logic [7:0]    head_ff [3];
   logic [SW-1:0] slot_ff, slot_in;
   logic [RW-1:0] region_ff, region_in;
   logic [31:0]   cap_ff, cap_in;
   logic [31:0]   filt_ff, filt_in;

   logic        is_cap;
   logic [15:0] hdr_new, len, snap16, keep16;
   logic [7:0]  type_new;
   logic        drop;
   logic [SW:0] off_mod, slot_sum;

   assign is_cap = accept && (cmd == CMD_CAPTURE);

   // Header length and type byte as updated by this beat.
   always_comb begin
      hdr_new  = hdr_ff;
      type_new = type_ff;
      if (count_ff == 16'd3) begin
         hdr_new = {data_byte, head_ff[2]};
         if (hdr_new <= 16'd3) begin
            type_new = (hdr_new == 16'd3) ? data_byte : head_ff[hdr_new[1:0]];
         end
      end else if (count_ff >= 16'd4 && count_ff == hdr_ff) begin
         type_new = data_byte;
      end
   end

   // Frame length, drop decision and kept length.
   always_comb begin
      len  = (count_ff == LEN_MAX) ? count_ff : count_ff + 16'd1;
      drop = (len <= LEN_MIN) || (hdr_new >= len) ||
             (filt_data && ((type_new & TYPE_MASK) == TYPE_DATA)) ||
             (filt_beacon && ((type_new & TYPE_MASK) == TYPE_BEACON));
      snap16 = (16'(snap_length) > 16'(SLOT_BYTES)) ? 16'(SLOT_BYTES) : 16'(snap_length);
      keep16 = (len < snap16) ? len : snap16;
   end

   assign kept    = is_cap && frame_end && !drop;
   assign dropped = is_cap && frame_end && drop;

   always_comb begin
      wr.byte_we   = is_cap && (count_ff < 16'(SLOT_BYTES));
      wr.commit    = kept;
      wr.keep      = keep16[8:0];
      wr.frame_len = len;
   end
   assign wr_slot   = slot_ff;
   assign wr_region = region_ff;
   assign wr_idx    = count_ff[IW-1:0];

   // Read slot: offset reduced modulo the slot count, then added to the oldest.
   always_comb begin
      off_mod = '0;
      for (int k = 5; k >= 0; k--) begin
         off_mod = {off_mod[SW-1:0], slot_offset[k]};
         if (off_mod >= (SW+1)'(NUM_SLOTS)) begin
            off_mod = off_mod - (SW+1)'(NUM_SLOTS);
         end
      end
      slot_sum = {1'b0, slot_ff} + off_mod;
      if (slot_sum >= (SW+1)'(NUM_SLOTS)) begin
         slot_sum = slot_sum - (SW+1)'(NUM_SLOTS);
      end
      rd_slot = slot_sum[SW-1:0];
   end

   // Next state of the counters and ring pointers.
   always_comb begin
      count_in  = count_ff;
      hdr_in    = hdr_ff;
      type_in   = type_ff;
      slot_in   = slot_ff;
      region_in = region_ff;
      cap_in    = cap_ff;
      filt_in   = filt_ff;
      if (is_cap) begin
         if (frame_end) begin
            count_in = '0;
            hdr_in   = '0;
            type_in  = '0;
            cap_in   = cap_ff + 32'd1;
            if (drop) begin
               filt_in = filt_ff + 32'd1;
            end else begin
               slot_in   = (slot_ff == SW'(NUM_SLOTS - 1)) ? '0 : slot_ff + SW'(1);
               region_in = (region_ff == RW'(NUM_SLOTS)) ? '0 : region_ff + RW'(1);
            end
         end else begin
            count_in = len;
            hdr_in   = hdr_new;
            type_in  = type_new;
         end
      end
   end

   assign cap_total  = cap_in;
   assign filt_total = filt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         hdr_ff    <= '0;
         type_ff   <= '0;
         slot_ff   <= '0;
         region_ff <= '0;
         cap_ff    <= '0;
         filt_ff   <= '0;
      end else begin
         count_ff  <= count_in;
         hdr_ff    <= hdr_in;
         type_ff   <= type_in;
         slot_ff   <= slot_in;
         region_ff <= region_in;
         cap_ff    <= cap_in;
         filt_ff   <= filt_in;
      end
   end

   // The first three bytes are kept for short header lengths.
   always_ff @(posedge clock) begin
      if (is_cap && count_ff < 16'd3) begin
         head_ff[count_ff[1:0]] <= data_byte;
      end
   end

endmodule

/* rtl/rtcf_ring.sv */
// Ring storage: slot descriptors, slot valid bits and the byte memory with
// one spare region that takes the frame being captured. Depends on rtcf_pkg.
module rtcf_ring
   import rtcf_pkg::*;
#(
   parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
   parameter int SLOT_BYTES = SLOT_BYTES_DEF,
   localparam int SW = $clog2(NUM_SLOTS),
   localparam int RW = $clog2(NUM_SLOTS + 1),
   localparam int IW = $clog2(SLOT_BYTES),
   localparam int AW = $clog2((NUM_SLOTS + 1) * SLOT_BYTES),
   localparam int MW = RW + 9 + 16 + 32 + 20
) (
   input  logic          clock,
   input  logic          reset,
   input  cap_write_type wr,
   input  logic [SW-1:0] wr_slot,
   input  logic [RW-1:0] wr_region,
   input  logic [IW-1:0] wr_idx,
   input  logic [7:0]    wr_data,
   input  logic [31:0]   wr_seconds,
   input  logic [19:0]   wr_micros,
   input  logic          rd_en,
   input  logic [SW-1:0] rd_slot,
   input  logic [7:0]    rd_offset,
   output logic          rd_hit,
   output logic [8:0]    rd_stored,
   output logic [15:0]   rd_orig,
   output logic [31:0]   rd_seconds,
   output logic [19:0]   rd_micros,
   output logic [7:0]    rd_byte
);

   logic [MW-1:0]  meta_mem [NUM_SLOTS];
   logic [7:0]     byte_mem [(NUM_SLOTS + 1) * SLOT_BYTES];
   logic [NUM_SLOTS-1:0] valid_ff;

   logic [MW-1:0] meta_s1_ff;
   logic          vld_s1_ff;
   logic [7:0]    off_s1_ff;
   logic          hit_s2_ff, byte_ok_s2_ff;
   logic [MW-RW-1:0] fields_s2_ff;
   logic [7:0]    byte_s2_ff;

   logic [RW-1:0] region_s1;
   logic [8:0]    stored_s1;
   logic          hit_s1, byte_ok_s1;
   logic [AW-1:0] wr_addr, rd_addr;

   assign wr_addr = AW'(wr_region) * AW'(SLOT_BYTES) + AW'(wr_idx);

   // Descriptor memory: written at commit, read into a register on a read beat.
   always_ff @(posedge clock) begin
      if (wr.commit) begin
         meta_mem[wr_slot] <= {wr_region, wr.keep, wr.frame_len, wr_seconds, wr_micros};
      end
      if (rd_en) begin
         meta_s1_ff <= meta_mem[rd_slot];
         vld_s1_ff  <= valid_ff[rd_slot];
         off_s1_ff  <= rd_offset;
      end
   end

   // Slot valid bits mark slots that were ever committed.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.commit) begin
         valid_ff[wr_slot] <= 1'b1;
      end
   end

   // Second read stage: the descriptor gives the byte region.
   always_comb begin
      region_s1  = meta_s1_ff[MW-1 -: RW];
      stored_s1  = meta_s1_ff[MW-RW-1 -: 9];
      hit_s1     = vld_s1_ff && (stored_s1 != 9'd0);
      byte_ok_s1 = hit_s1 && (9'(off_s1_ff) < stored_s1) &&
                   (16'(off_s1_ff) < 16'(SLOT_BYTES));
      rd_addr    = AW'(region_s1) * AW'(SLOT_BYTES) + AW'(off_s1_ff);
   end

   // Byte memory: capture writes the spare region, reads take the slot's.
   always_ff @(posedge clock) begin
      if (wr.byte_we) begin
         byte_mem[wr_addr] <= wr_data;
      end
      byte_s2_ff    <= byte_mem[rd_addr];
      hit_s2_ff     <= hit_s1;
      byte_ok_s2_ff <= byte_ok_s1;
      fields_s2_ff  <= meta_s1_ff[MW-RW-1:0];
   end

   // Empty slots and out-of-range bytes read as zero.
   always_comb begin
      rd_hit     = hit_s2_ff;
      rd_stored  = hit_s2_ff ? fields_s2_ff[76:68] : '0;
      rd_orig    = hit_s2_ff ? fields_s2_ff[67:52] : '0;
      rd_seconds = hit_s2_ff ? fields_s2_ff[51:20] : '0;
      rd_micros  = hit_s2_ff ? fields_s2_ff[19:0]  : '0;
      rd_byte    = byte_ok_s2_ff ? byte_s2_ff : '0;
   end

endmodule

/* rtl/rtcf_rsp_queue.sv */
// Three-beat response queue that absorbs the read pipeline when the receiver
// stalls. Depends on rtcf_pkg.
module rtcf_rsp_queue
   import rtcf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  rsp_type    push_data,
   input  logic       pop,
   output logic       not_empty,
   output rsp_type    head,
   output logic [1:0] level
);

   rsp_type    mem_ff [3];
   logic [1:0] wptr_ff, wptr_in, rptr_ff, rptr_in, cnt_ff, cnt_in;

   // Pointer and level update.
   always_comb begin
      wptr_in = push ? ((wptr_ff == 2'd2) ? 2'd0 : wptr_ff + 2'd1) : wptr_ff;
      rptr_in = pop  ? ((rptr_ff == 2'd2) ? 2'd0 : rptr_ff + 2'd1) : rptr_ff;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

   assign not_empty = (cnt_ff != 2'd0);
   assign head      = mem_ff[rptr_ff];
   assign level     = cnt_ff;

endmodule

/* rtl/radiotap_capture_filter_ring.sv */
// Top level of the radiotap capture filter ring: stream ports, register port,
// read pipeline sideband. Depends on rtcf_pkg, rtcf_capture, rtcf_ring and
// rtcf_rsp_queue.
//
// Every request beat gives exactly one response beat, in order. A capture
// beat (tuser 0) carries one frame byte; tlast marks the frame's last byte,
// and that beat's response flags whether the frame was kept or dropped.
// Read beats (tuser 1 header, 2 byte) address a slot counted from the oldest.
// A response passes the descriptor memory read, the byte memory read (its
// address comes from the descriptor) and the response queue, in that order.
// One beat is taken per cycle while req_tready is high; the byte memory holds
// one spare region, so a frame is written as it arrives and a commit only
// updates a descriptor.
// Reset empties every slot and clears counters; registers return to no
// filtering and a snap length of 256. No clearing pass is needed.
// When the receiver stalls, up to three beats are held in flight and in the
// queue, and req_tready drops until the receiver takes one.
module radiotap_capture_filter_ring
   import rtcf_pkg::*;
#(
   parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
   parameter int SLOT_BYTES = SLOT_BYTES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // data_byte[7:0], stamp_seconds[39:8], stamp_micros[59:40],
   // slot_offset[65:60], byte_offset[73:66], zero pad
   input  logic [79:0]  req_tdata,
   input  logic         req_tlast,
   // command
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // entry_valid[0], stored_length[9:1], original_length[25:10],
   // entry_seconds[57:26], entry_micros[77:58], read_data[85:78],
   // frame_kept[86], frame_dropped[87], captured_total[119:88],
   // filtered_total[151:120]
   output logic [151:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int SW = $clog2(NUM_SLOTS);
   localparam int RW = $clog2(NUM_SLOTS + 1);
   localparam int IW = $clog2(SLOT_BYTES);

   logic       filt_data_ff, filt_beacon_ff;
   logic [8:0] snap_ff;

   logic          accept, csr_write;
   cmd_type       cmd;
   cap_write_type wr;
   logic [SW-1:0] wr_slot, rd_slot;
   logic [RW-1:0] wr_region;
   logic [IW-1:0] wr_idx;
   logic          kept, dropped;
   logic [31:0]   cap_total, filt_total;

   logic          rd_hit;
   logic [8:0]    rd_stored;
   logic [15:0]   rd_orig;
   logic [31:0]   rd_seconds;
   logic [19:0]   rd_micros;
   logic [7:0]    rd_byte;

   logic          p1_vld_ff, p2_vld_ff;
   cmd_type       p1_cmd_ff, p2_cmd_ff;
   logic          p1_kept_ff, p2_kept_ff, p1_drop_ff, p2_drop_ff;
   logic [31:0]   p1_cap_ff, p2_cap_ff, p1_filt_ff, p2_filt_ff;

   rsp_type       rsp_beat, q_head;
   logic          q_not_empty, pop;
   logic [1:0]    q_level;
   logic [2:0]    in_flight;

   assign cmd    = cmd_type'(req_tuser);
   assign accept = req_tvalid && req_tready;
   assign pop    = rsp_tvalid && rsp_tready;

   // Accept while the pipeline plus queue has room for one more beat.
   assign in_flight  = {1'b0, q_level} + {2'b0, p1_vld_ff} + {2'b0, p2_vld_ff};
   assign req_tready = (in_flight - {2'b0, pop}) < 3'd3;

   // Configuration registers.
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         filt_data_ff   <= 1'b0;
         filt_beacon_ff <= 1'b0;
         snap_ff        <= SNAP_RESET;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_FILT_DATA:   filt_data_ff   <= csr_pwdata[0];
            REG_FILT_BEACON: filt_beacon_ff <= csr_pwdata[0];
            REG_SNAP:        snap_ff        <= csr_pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_FILT_DATA:   csr_prdata = {31'd0, filt_data_ff};
         REG_FILT_BEACON: csr_prdata = {31'd0, filt_beacon_ff};
         REG_SNAP:        csr_prdata = {23'd0, snap_ff};
         default:         csr_prdata = '0;
      endcase
   end

   rtcf_capture #(.NUM_SLOTS(NUM_SLOTS), .SLOT_BYTES(SLOT_BYTES)) u_capture (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .cmd         (cmd),
      .data_byte   (req_tdata[7:0]),
      .frame_end   (req_tlast),
      .slot_offset (req_tdata[65:60]),
      .filt_data   (filt_data_ff),
      .filt_beacon (filt_beacon_ff),
      .snap_length (snap_ff),
      .wr          (wr),
      .wr_slot     (wr_slot),
      .wr_region   (wr_region),
      .wr_idx      (wr_idx),
      .rd_slot     (rd_slot),
      .kept        (kept),
      .dropped     (dropped),
      .cap_total   (cap_total),
      .filt_total  (filt_total)
   );

   rtcf_ring #(.NUM_SLOTS(NUM_SLOTS), .SLOT_BYTES(SLOT_BYTES)) u_ring (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .wr_slot    (wr_slot),
      .wr_region  (wr_region),
      .wr_idx     (wr_idx),
      .wr_data    (req_tdata[7:0]),
      .wr_seconds (req_tdata[39:8]),
      .wr_micros  (req_tdata[59:40]),
      .rd_en      (accept && (cmd == CMD_READ_HDR || cmd == CMD_READ_BYTE)),
      .rd_slot    (rd_slot),
      .rd_offset  (req_tdata[73:66]),
      .rd_hit     (rd_hit),
      .rd_stored  (rd_stored),
      .rd_orig    (rd_orig),
      .rd_seconds (rd_seconds),
      .rd_micros  (rd_micros),
      .rd_byte    (rd_byte)
   );

   // Sideband that travels alongside the two memory read stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= accept;
         p2_vld_ff <= p1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_cmd_ff  <= cmd;
      p1_kept_ff <= kept;
      p1_drop_ff <= dropped;
      p1_cap_ff  <= cap_total;
      p1_filt_ff <= filt_total;
      p2_cmd_ff  <= p1_cmd_ff;
      p2_kept_ff <= p1_kept_ff;
      p2_drop_ff <= p1_drop_ff;
      p2_cap_ff  <= p1_cap_ff;
      p2_filt_ff <= p1_filt_ff;
   end

   // Assemble the response beat; slot fields only for read commands.
   always_comb begin
      rsp_beat                = '0;
      rsp_beat.captured_total = p2_cap_ff;
      rsp_beat.filtered_total = p2_filt_ff;
      rsp_beat.frame_kept     = p2_kept_ff;
      rsp_beat.frame_dropped  = p2_drop_ff;
      if (p2_cmd_ff == CMD_READ_HDR || p2_cmd_ff == CMD_READ_BYTE) begin
         rsp_beat.entry_valid     = rd_hit;
         rsp_beat.stored_length   = rd_stored;
         rsp_beat.original_length = rd_orig;
         rsp_beat.entry_seconds   = rd_seconds;
         rsp_beat.entry_micros    = rd_micros;
         if (p2_cmd_ff == CMD_READ_BYTE) begin
            rsp_beat.read_data = rd_byte;
         end
      end
   end

   rtcf_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (p2_vld_ff),
      .push_data (rsp_beat),
      .pop       (pop),
      .not_empty (q_not_empty),
      .head      (q_head),
      .level     (q_level)
   );

   assign rsp_tvalid = q_not_empty;
   assign rsp_tdata  = q_head;

   // Beats in the read pipeline never outnumber the queue's free entries.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      in_flight <= 3'd3) else $error("response queue overrun");

   // A frame end is either kept or dropped, never both.
   a_one_verdict: assert property (@(posedge clock) disable iff (reset)
      p2_vld_ff |-> !(p2_kept_ff && p2_drop_ff)) else $error("double verdict");

   // Verdicts only come from capture beats.
   a_verdict_cmd: assert property (@(posedge clock) disable iff (reset)
      (p2_vld_ff && (p2_kept_ff || p2_drop_ff)) |-> (p2_cmd_ff == CMD_CAPTURE))
      else $error("verdict on a read beat");

   // A kept frame end right after reset must show a nonzero captured total.
   a_cap_count: assert property (@(posedge clock) disable iff (reset)
      (p1_vld_ff && p1_kept_ff) |-> (p1_cap_ff != 32'd0 || $past(reset) == 1'b0))
      else $error("captured total not advanced");

endmodule

/* bench/radiotap_capture_filter_ring_tb.sv */
// Self-checking testbench for the radiotap capture filter ring.
// Drives capture and slot-read beats plus register writes; depends on rtcf_pkg and the DUT.
`timescale 1ns / 1ps

module radiotap_capture_filter_ring_tb;
   import rtcf_pkg::*;

   localparam int RING_SLOTS = 64;
   localparam int RING_BYTES = 256;
   localparam int CYCLE_LIMIT = 2000000;

   // Captured-frame ring model with its queue of expected response beats.
   class capture_ring_scoreboard;
      bit          filt_data;
      bit          filt_beacon;
      logic [8:0]  snap_len;
      logic [7:0]  ring_mem [RING_SLOTS][RING_BYTES];
      logic [8:0]  ring_stored [RING_SLOTS];
      logic [15:0] ring_orig [RING_SLOTS];
      logic [31:0] ring_sec [RING_SLOTS];
      logic [19:0] ring_usec [RING_SLOTS];
      logic [7:0]  stage [RING_BYTES];
      logic [5:0]  head_slot;
      logic [15:0] byte_count;
      logic [15:0] hdr_len;
      logic [7:0]  fc_byte;
      logic [31:0] seen_frames;
      logic [31:0] dropped_frames;
      rsp_type     pending_rsp [$];
      int          error_count;
      int          kept_frames;

      function new();
         filt_data = 0;
         filt_beacon = 0;
         snap_len = SNAP_RESET;
         foreach (ring_stored[i]) ring_stored[i] = '0;
         head_slot = '0;
         byte_count = '0;
         hdr_len = '0;
         fc_byte = '0;
         seen_frames = '0;
         dropped_frames = '0;
         error_count = 0;
         kept_frames = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] val);
         case (idx)
            REG_FILT_DATA: filt_data = val[0];
            REG_FILT_BEACON: filt_beacon = val[0];
            REG_SNAP: snap_len = val[8:0];
            default: ;
         endcase
      endfunction

      // Note one accepted request beat and queue its expected response.
      function void note_request(cmd_type cmd, logic [7:0] data, bit last,
                                 logic [31:0] sec, logic [19:0] usec,
                                 logic [5:0] slot_ofs, logic [7:0] byte_ofs);
         rsp_type r;
         logic [5:0] s;
         int keep;
         int snap;
         bit drop;
         logic [7:0] t;
         r = '0;
         if (cmd == CMD_CAPTURE) begin
            if (byte_count < RING_BYTES) stage[byte_count] = data;
            if (byte_count == 3) begin
               hdr_len = {data, stage[2]};
               if (hdr_len <= 3) fc_byte = (hdr_len == 3) ? data : stage[hdr_len];
            end else if (byte_count >= 4 && byte_count == hdr_len) begin
               fc_byte = data;
            end
            if (byte_count != LEN_MAX) byte_count++;
            if (last) begin
               t = fc_byte & TYPE_MASK;
               seen_frames++;
               drop = (byte_count <= LEN_MIN) || (hdr_len >= byte_count) ||
                      (filt_data && t == TYPE_DATA) || (filt_beacon && t == TYPE_BEACON);
               if (drop) begin
                  dropped_frames++;
               end else begin
                  snap = (snap_len < RING_BYTES) ? snap_len : RING_BYTES;
                  keep = (byte_count < snap) ? byte_count : snap;
                  for (int i = 0; i < keep; i++) ring_mem[head_slot][i] = stage[i];
                  ring_stored[head_slot] = keep;
                  ring_orig[head_slot] = byte_count;
                  ring_sec[head_slot] = sec;
                  ring_usec[head_slot] = usec;
                  head_slot++;
                  kept_frames++;
               end
               r.frame_kept = !drop;
               r.frame_dropped = drop;
               byte_count = '0;
               hdr_len = '0;
               fc_byte = '0;
            end
         end else if (cmd == CMD_READ_HDR || cmd == CMD_READ_BYTE) begin
            s = head_slot + slot_ofs;
            if (ring_stored[s] != 0) begin
               r.entry_valid = 1;
               r.stored_length = ring_stored[s];
               r.original_length = ring_orig[s];
               r.entry_seconds = ring_sec[s];
               r.entry_micros = ring_usec[s];
               if (cmd == CMD_READ_BYTE && byte_ofs < ring_stored[s])
                  r.read_data = ring_mem[s][byte_ofs];
            end
         end
         r.captured_total = seen_frames;
         r.filtered_total = dropped_frames;
         pending_rsp.push_back(r);
      endfunction

      // Compare one response beat with the oldest expectation.
      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_rsp.size() == 0) begin
            $error("unexpected response beat %h", got);
            error_count++;
            return;
         end
         want = pending_rsp.pop_front();
         if (got.entry_valid !== want.entry_valid) begin
            $error("entry_valid exp %0h got %0h", want.entry_valid, got.entry_valid);
            error_count++;
         end
         if (got.stored_length !== want.stored_length) begin
            $error("stored_length exp %0h got %0h", want.stored_length, got.stored_length);
            error_count++;
         end
         if (got.original_length !== want.original_length) begin
            $error("original_length exp %0h got %0h", want.original_length,
                   got.original_length);
            error_count++;
         end
         if (got.entry_seconds !== want.entry_seconds) begin
            $error("entry_seconds exp %0h got %0h", want.entry_seconds, got.entry_seconds);
            error_count++;
         end
         if (got.entry_micros !== want.entry_micros) begin
            $error("entry_micros exp %0h got %0h", want.entry_micros, got.entry_micros);
            error_count++;
         end
         if (got.read_data !== want.read_data) begin
            $error("read_data exp %0h got %0h", want.read_data, got.read_data);
            error_count++;
         end
         if (got.frame_kept !== want.frame_kept) begin
            $error("frame_kept exp %0h got %0h", want.frame_kept, got.frame_kept);
            error_count++;
         end
         if (got.frame_dropped !== want.frame_dropped) begin
            $error("frame_dropped exp %0h got %0h", want.frame_dropped, got.frame_dropped);
            error_count++;
         end
         if (got.captured_total !== want.captured_total) begin
            $error("captured_total exp %0h got %0h", want.captured_total, got.captured_total);
            error_count++;
         end
         if (got.filtered_total !== want.filtered_total) begin
            $error("filtered_total exp %0h got %0h", want.filtered_total, got.filtered_total);
            error_count++;
         end
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [79:0]   req_tdata;
   logic          req_tlast;
   logic [1:0]    req_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [151:0]  rsp_tdata;
   logic          csr_psel;
   logic          csr_penable;
   logic          csr_pwrite;
   logic [3:0]    csr_paddr;
   logic [31:0]   csr_pwdata;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   capture_ring_scoreboard ring_sb;
   int  send_idle_pct;
   int  stall_pct;
   bit  hold_off;
   int  cycle_count;
   int  beats_sent;

   radiotap_capture_filter_ring u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Cycle counter with a timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("radiotap_capture_filter_ring: mismatch");
         $finish;
      end
   end

   // Receiver: check each accepted response beat, stall at random.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) ring_sb.check_response(rsp_type'(rsp_tdata));
   end

   always @(negedge clock) begin
      if (reset) rsp_tready <= 0;
      else rsp_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
   end

   // Send one request beat, idling at random before it. The beat stays
   // valid after acceptance until the next beat or an idle cycle replaces it.
   task automatic send_beat(cmd_type cmd, logic [7:0] data, bit last,
                            logic [31:0] sec, logic [19:0] usec,
                            logic [5:0] slot_ofs, logic [7:0] byte_ofs);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= cmd;
      req_tlast <= last;
      req_tdata <= {6'd0, byte_ofs, slot_ofs, usec, sec, data};
      do @(posedge clock); while (!req_tready);
      ring_sb.note_request(cmd, data, last, sec, usec, slot_ofs, byte_ofs);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic capture_frame(int len, logic [15:0] hlen, logic [7:0] fc);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         b = $urandom;
         if (i == 2) b = hlen[7:0];
         if (i == 3) b = hlen[15:8];
         if (i == hlen && i >= 4) b = fc;
         send_beat(CMD_CAPTURE, b, i == len - 1, $urandom, $urandom_range(999999),
                   $urandom, $urandom);
      end
   endtask

   task automatic read_random();
      cmd_type c;
      c = ($urandom_range(3) == 0) ? CMD_READ_HDR : CMD_READ_BYTE;
      if ($urandom_range(30) == 0) c = CMD_NONE;
      send_beat(c, $urandom, $urandom, $urandom, $urandom_range(999999),
                $urandom, $urandom);
   endtask

   // Wait for all responses, let the pipeline drain, then write a register.
   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      req_tvalid <= 0;
      while (ring_sb.pending_rsp.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      ring_sb.write_reg(idx, val);
   endtask

   task automatic random_traffic(int beats);
      int start;
      logic [7:0] fc;
      int len;
      start = beats_sent;
      while (beats_sent - start < beats) begin
         case ($urandom_range(9))
            0, 1, 2: read_random();
            3: capture_frame($urandom_range(1, 12), $urandom_range(0, 16), $urandom);
            default: begin
               fc = ($urandom_range(2) == 0) ? TYPE_DATA | $urandom_range(3) :
                    ($urandom_range(1) == 0) ? TYPE_BEACON | $urandom_range(3) : $urandom;
               len = ($urandom_range(7) == 0) ? $urandom_range(200, 300)
                                               : $urandom_range(9, 40);
               capture_frame(len, $urandom_range(4, 8), fc);
            end
         endcase
      end
   endtask

   initial begin
      ring_sb = new();
      reset = 1; req_tvalid = 0; req_tdata = '0; req_tlast = 0; req_tuser = CMD_CAPTURE;
      rsp_tready = 0; csr_psel = 0; csr_penable = 0; csr_pwrite = 0;
      csr_paddr = '0; csr_pwdata = '0;
      send_idle_pct = 0; stall_pct = 0; hold_off = 0; cycle_count = 0; beats_sent = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: empty reads, short and bad frames, header length extremes.
      send_beat(CMD_READ_BYTE, 8'hFF, 1, '1, 999999, 6'h3F, 8'hFF);
      send_beat(CMD_NONE, 8'h00, 0, '0, 0, '0, '0);
      capture_frame(8, 4, 8'h00);
      capture_frame(9, 3, 8'h00);
      capture_frame(10, 10, 8'h00);
      capture_frame(12, 0, 8'hFF);
      send_beat(CMD_READ_HDR, 0, 0, 0, 0, 6'h3F, 0);
      send_beat(CMD_READ_BYTE, 0, 0, 0, 0, 6'h3F, 8'd11);

      // Filtering and small snap length.
      write_csr(REG_FILT_DATA, 1);
      write_csr(REG_FILT_BEACON, 1);
      write_csr(REG_SNAP, 41);
      random_traffic(250);
      write_csr(REG_FILT_DATA, 0);
      write_csr(REG_SNAP, 256);
      send_idle_pct = 73;
      random_traffic(300);
      write_csr(REG_FILT_BEACON, 0);
      write_csr(REG_SNAP, 100);
      send_idle_pct = 0; stall_pct = 73;
      random_traffic(300);

      // Long hold-off on the receiver so the input backs up.
      fork
         begin
            hold_off = 1;
            repeat (200) @(negedge clock);
            hold_off = 0;
         end
         random_traffic(100);
      join
      write_csr(REG_FILT_DATA, 1);
      write_csr(REG_SNAP, 255);
      send_idle_pct = 25; stall_pct = 25;
      random_traffic(250);

      // Read the first bytes of the newest slot back with no idling.
      send_idle_pct = 0; stall_pct = 0;
      for (int i = 0; i < 4; i++) send_beat(CMD_READ_BYTE, 0, 0, 0, 0, 6'h3F, i);
      random_traffic(300);

      req_tvalid <= 0;
      while (ring_sb.pending_rsp.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      $display("Sent %0d beats; %0d frames kept, %0d frames dropped.",
               beats_sent, ring_sb.kept_frames, ring_sb.dropped_frames);
      if (ring_sb.error_count == 0 && ring_sb.pending_rsp.size() == 0)
         $display("radiotap_capture_filter_ring: match");
      else
         $display("radiotap_capture_filter_ring: mismatch");
      $finish;
   end

endmodule

/* sim.f */
rtl/rtcf_pkg.sv
rtl/rtcf_capture.sv
rtl/rtcf_ring.sv
rtl/rtcf_rsp_queue.sv
rtl/radiotap_capture_filter_ring.sv
bench/radiotap_capture_filter_ring_tb.sv
